// ===== rtl/rppf_pkg.sv =====
// ----------------------------------------------------------------------------
// rppf_pkg
// Types and constants shared by the RSSI proximity presence filter.
// ----------------------------------------------------------------------------
package rppf_pkg;

    localparam int unsigned TIME_W     = 40;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_DBM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPARTURE_DBM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SAMPLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRESHNESS_MS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_MS    = 3'd5;

    // item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic signed [7:0] RSSI_INVALID = 8'sd127;
    localparam logic [3:0]        ENTRY_MAX    = 4'd15;

    // register reset values
    localparam logic signed [7:0] RST_CONNECT_DBM   = -8'sd60;
    localparam logic signed [7:0] RST_DEPARTURE_DBM = -8'sd75;
    localparam logic [3:0]        RST_ENTRY_SAMPLES = 4'd3;
    localparam logic [15:0]       RST_TIMEOUT_MS    = 16'd10000;
    localparam logic [15:0]       RST_FRESHNESS_MS  = 16'd1500;
    localparam logic [15:0]       RST_WARNING_MS    = 16'd3000;

    typedef struct packed {
        logic              cmd;
        logic signed [7:0] rssi_dbm;
        logic [TIME_W-1:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic               is_near;
        logic               departure_grace;
        logic               departure_warning;
        logic               has_filtered;
        logic signed [15:0] filtered_dbm_q8;
    } out_item_t;

    typedef struct packed {
        logic signed [7:0] connect_dbm;
        logic signed [7:0] departure_dbm;
        logic [3:0]        entry_samples_needed;
        logic [15:0]       departure_timeout_ms;
        logic [15:0]       freshness_ms;
        logic [15:0]       warning_delay_ms;
    } cfg_t;

endpackage

// ===== rtl/rppf_core.sv =====
// ----------------------------------------------------------------------------
// rppf_core
// Presence state, EWMA update and status evaluation for one request.
// ----------------------------------------------------------------------------
module rppf_core import rppf_pkg::*; #(
    parameter int TIME_BITS = 40,
    parameter int FRAC_BITS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam int SUM_W = (((8 + FRAC_BITS) > 18) ? (8 + FRAC_BITS) : 18) + 1;
    localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Q_MIN = SUM_W'(-32768);

    logic signed [15:0]    level_reg, level_next;
    logic                  fvalid_reg, fvalid_next;
    logic [3:0]            count_reg, count_next;
    logic                  near_reg, near_next;
    logic [TIME_BITS-1:0]  lqt_reg, lqt_next;
    logic [TIME_BITS-1:0]  lst_reg, lst_next;

    logic [TIME_BITS-1:0]  now, diff_q, diff_s, tmo, fresh, warn;
    logic                  lt_q, lt_s, near_old, is_sample, clr;
    logic                  eff_valid, eff_near;
    logic [3:0]            eff_count, cnt_inc;
    logic signed [SUM_W-1:0] rssi_q, lvl_x, sum, bias, quot, cand, lvl_new_x;
    logic signed [SUM_W-1:0] conn_q, dep_q;
    logic                  qual_upd;
    logic                  o_lt_q, o_lt_s, o_near, o_grace;
    logic [TIME_BITS-1:0]  o_dq, o_ds;

    always_comb begin
        now   = TIME_BITS'(item.time_ms);
        tmo   = TIME_BITS'(cfg.departure_timeout_ms);
        fresh = TIME_BITS'(cfg.freshness_ms);
        warn  = TIME_BITS'(cfg.warning_delay_ms);

        diff_q = now - lqt_reg;
        diff_s = now - lst_reg;
        lt_q   = now < lqt_reg;
        lt_s   = now < lst_reg;

        near_old  = near_reg && (lt_q || (diff_q < tmo));
        is_sample = (item.cmd == CMD_SAMPLE) && (item.rssi_dbm != RSSI_INVALID);
        // expired presence wipes everything before the sample is used
        clr       = is_sample && near_reg && !near_old;

        eff_valid = fvalid_reg && !clr;
        eff_near  = near_reg && !clr;
        eff_count = clr ? 4'd0 : count_reg;

        // EWMA: (rssi + 3*level) / 4, truncated toward zero; the first sample is taken as is
        rssi_q = SUM_W'(item.rssi_dbm) <<< FRAC_BITS;
        lvl_x  = SUM_W'(level_reg);
        sum    = rssi_q + lvl_x + (lvl_x <<< 1);
        bias   = {{(SUM_W-2){1'b0}}, {2{sum[SUM_W-1]}}};
        quot   = (sum + bias) >>> 2;
        cand   = eff_valid ? quot : rssi_q;

        conn_q = SUM_W'(cfg.connect_dbm) <<< FRAC_BITS;
        dep_q  = SUM_W'(cfg.departure_dbm) <<< FRAC_BITS;

        level_next  = level_reg;
        fvalid_next = fvalid_reg;
        count_next  = count_reg;
        near_next   = near_reg;
        lqt_next    = lqt_reg;
        lst_next    = lst_reg;
        qual_upd    = 1'b0;
        cnt_inc     = (eff_count == ENTRY_MAX) ? eff_count : eff_count + 4'd1;

        if (is_sample) begin
            if (cand > Q_MAX) begin
                level_next = 16'sh7FFF;
            end else if (cand < Q_MIN) begin
                level_next = -16'sh8000;
            end else begin
                level_next = cand[15:0];
            end
            fvalid_next = 1'b1;
            lst_next    = now;
            near_next   = eff_near;
            lqt_next    = clr ? '0 : lqt_reg;
            count_next  = eff_count;
            lvl_new_x   = SUM_W'(level_next);
            if (!eff_near) begin
                if (lvl_new_x >= conn_q) begin
                    count_next = cnt_inc;
                    if (cnt_inc >= cfg.entry_samples_needed) begin
                        near_next = 1'b1;
                        lqt_next  = now;
                        qual_upd  = 1'b1;
                    end
                end else begin
                    count_next = 4'd0;
                end
            end else if (lvl_new_x > dep_q && now > lqt_reg) begin
                lqt_next = now;
                qual_upd = 1'b1;
            end
        end else begin
            lvl_new_x = lvl_x;
        end

        // status against the updated state; a fresh timestamp means zero age
        o_lt_q = qual_upd ? 1'b0 : lt_q;
        o_dq   = qual_upd ? '0 : diff_q;
        o_lt_s = is_sample ? 1'b0 : lt_s;
        o_ds   = is_sample ? '0 : diff_s;

        o_near  = near_next && (o_lt_q || (o_dq < tmo));
        o_grace = o_near && fvalid_next && !o_lt_s &&
                  ((SUM_W'(level_next) <= dep_q) || (o_ds >= fresh));

        result.is_near           = o_near;
        result.departure_grace   = o_grace;
        result.departure_warning = o_grace && !o_lt_q && (o_dq >= warn);
        result.has_filtered      = fvalid_next;
        result.filtered_dbm_q8   = fvalid_next ? level_next : 16'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            fvalid_reg <= 1'b0;
            count_reg  <= '0;
            near_reg   <= 1'b0;
            lqt_reg    <= '0;
            lst_reg    <= '0;
        end else if (step) begin
            level_reg  <= level_next;
            fvalid_reg <= fvalid_next;
            count_reg  <= count_next;
            near_reg   <= near_next;
            lqt_reg    <= lqt_next;
            lst_reg    <= lst_next;
        end
    end

endmodule

// ===== rtl/rssi_proximity_presence_filter_unit.sv =====
// ----------------------------------------------------------------------------
// rssi_proximity_presence_filter_unit
// EWMA presence detector with entry hysteresis and departure timeout.
//
//  channel | direction | signals                           | payload
//  --------+-----------+-----------------------------------+------------
//  s_      | in        | s_valid, s_ready, s_data          | in_item_t
//  m_      | out       | m_valid, m_ready, m_data          | out_item_t
//  cfg_    | in        | cfg_valid, cfg_ready, cfg_index,  | 16-bit data
//          |           | cfg_data                          |
//
// One request per cycle sustained while m_ready stays high; an accepted
// request passes the input register, then the result register, where
// m_valid rises. The whole update lies between the registers.
// Reset clears presence state and loads register defaults; cfg_ready is
// always high. A stalled result holds; the input register takes one more
// request and s_ready then follows m_ready until the result leaves.
// ----------------------------------------------------------------------------
module rssi_proximity_presence_filter_unit import rppf_pkg::*; #(
    parameter int TIME_BITS = 40,
    parameter int FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t m_data_reg;
    logic      m_valid_reg;
    out_item_t result;
    logic      advance;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.connect_dbm          <= RST_CONNECT_DBM;
            cfg_reg.departure_dbm        <= RST_DEPARTURE_DBM;
            cfg_reg.entry_samples_needed <= RST_ENTRY_SAMPLES;
            cfg_reg.departure_timeout_ms <= RST_TIMEOUT_MS;
            cfg_reg.freshness_ms         <= RST_FRESHNESS_MS;
            cfg_reg.warning_delay_ms     <= RST_WARNING_MS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CONNECT_DBM:   cfg_reg.connect_dbm          <= cfg_data[7:0];
                REG_DEPARTURE_DBM: cfg_reg.departure_dbm        <= cfg_data[7:0];
                REG_ENTRY_SAMPLES: cfg_reg.entry_samples_needed <= cfg_data[3:0];
                REG_TIMEOUT_MS:    cfg_reg.departure_timeout_ms <= cfg_data;
                REG_FRESHNESS_MS:  cfg_reg.freshness_ms         <= cfg_data;
                REG_WARNING_MS:    cfg_reg.warning_delay_ms     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    rppf_core #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

endmodule

// ===== rtl/rppf_checker.sv =====
// ----------------------------------------------------------------------------
// rppf_checker
// Port-level checks on the presence filter result stream.
// ----------------------------------------------------------------------------
module rppf_checker import rppf_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_filtered |-> m_data.filtered_dbm_q8 == 16'sd0)
        else $error("empty average reported non-zero");

    a_warn_grace: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.departure_warning |-> m_data.departure_grace)
        else $error("warning without grace");

    a_grace_near: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.departure_grace |-> m_data.is_near && m_data.has_filtered)
        else $error("grace while not near or without average");

endmodule

bind rssi_proximity_presence_filter_unit rppf_checker u_rppf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/rssi_proximity_presence_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rssi_proximity_presence_filter_unit_tb
// Self-checking bench for the EWMA presence filter. Requests go in through
// a valid/ready sender with random gaps. An in-bench model of the average,
// the entry run, the exit timestamp and the timeout predicts each status.
// A monitor compares every result against the oldest prediction, while
// m_ready stalls at random. Register settings change between quiet phases.
// ----------------------------------------------------------------------------
module rssi_proximity_presence_filter_unit_tb;
    import rppf_pkg::*;

    localparam int          FRAC       = 8;
    localparam int          ONE_Q      = 1 << FRAC;
    localparam int          CYCLE_CAP  = 1000000;
    localparam int          N_PHASES   = 8;
    localparam int          PHASE_REQS = 152;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_WARNING_MS + CFG_IDX_W'(1);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    rssi_proximity_presence_filter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // presence model state
    cfg_t        regs;
    int          avg_q8;
    bit          avg_valid;
    logic [3:0]  strong_run;
    bit          near_latched;
    logic [39:0] exit_ms;
    logic [39:0] last_sample_ms;

    out_item_t   expected_status[$];

    int n_reqs     = 0;
    int n_checked  = 0;
    int n_fail     = 0;
    int n_settings = 0;
    int n_near     = 0;
    int n_warn     = 0;
    int cycles     = 0;
    bit s_calm     = 1'b0;
    bit m_calm     = 1'b0;
    int stall_left = 0;

    function automatic int sat16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void clear_presence();
        avg_q8         = 0;
        avg_valid      = 1'b0;
        strong_run     = '0;
        near_latched   = 1'b0;
        exit_ms        = '0;
        last_sample_ms = '0;
    endfunction

    function automatic bit near_at_ms(logic [39:0] t);
        if (!near_latched || t < exit_ms) return near_latched;
        return (t - exit_ms) < 40'(regs.departure_timeout_ms);
    endfunction

    function automatic bit grace_at_ms(logic [39:0] t);
        int dep_q8;
        dep_q8 = int'($signed(regs.departure_dbm)) * ONE_Q;
        if (!near_at_ms(t) || !avg_valid || t < last_sample_ms) return 1'b0;
        return avg_q8 <= dep_q8 || (t - last_sample_ms) >= 40'(regs.freshness_ms);
    endfunction

    function automatic bit warning_at_ms(logic [39:0] t);
        if (!grace_at_ms(t) || t < exit_ms) return 1'b0;
        return (t - exit_ms) >= 40'(regs.warning_delay_ms);
    endfunction

    // applies one request to the model and returns the status it reports
    function automatic out_item_t presence_update(in_item_t it);
        out_item_t   st;
        logic [39:0] t;
        int          rssi;
        int          conn_q8;
        int          dep_q8;
        t       = it.time_ms;
        rssi    = int'($signed(it.rssi_dbm));
        conn_q8 = int'($signed(regs.connect_dbm)) * ONE_Q;
        dep_q8  = int'($signed(regs.departure_dbm)) * ONE_Q;
        if (it.cmd == CMD_SAMPLE && it.rssi_dbm != RSSI_INVALID) begin
            // expired presence is wiped before the new sample counts
            if (near_latched && !near_at_ms(t)) clear_presence();
            if (!avg_valid) begin
                avg_q8    = sat16(rssi * ONE_Q);
                avg_valid = 1'b1;
            end else begin
                avg_q8 = sat16((rssi * ONE_Q + 3 * avg_q8) / 4);
            end
            last_sample_ms = t;
            if (!near_latched) begin
                if (avg_q8 >= conn_q8) begin
                    if (strong_run < ENTRY_MAX) strong_run++;
                    if (strong_run >= regs.entry_samples_needed) begin
                        near_latched = 1'b1;
                        exit_ms      = t;
                    end
                end else begin
                    strong_run = '0;
                end
            end else if (avg_q8 > dep_q8 && t > exit_ms) begin
                exit_ms = t;
            end
        end
        st.is_near           = near_at_ms(t);
        st.departure_grace   = grace_at_ms(t);
        st.departure_warning = warning_at_ms(t);
        st.has_filtered      = avg_valid;
        st.filtered_dbm_q8   = avg_valid ? 16'(avg_q8) : '0;
        return st;
    endfunction

    function automatic in_item_t mk_item(logic cmd, logic signed [7:0] rssi,
                                         logic [39:0] t);
        in_item_t it;
        it.cmd      = cmd;
        it.rssi_dbm = rssi;
        it.time_ms  = t;
        return it;
    endfunction

    function automatic logic [15:0] pick16(logic [15:0] lo_end, logic [15:0] hi_end,
                                           int lo, int hi);
        case ($urandom_range(0, 3))
            0:       return lo_end;
            1:       return hi_end;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        case ($urandom_range(0, 3))
            0:       c.connect_dbm = -8'sd127;
            1:       c.connect_dbm = 8'sd0;
            default: c.connect_dbm = -8'($urandom_range(30, 110));
        endcase
        case ($urandom_range(0, 3))
            0:       c.departure_dbm = -8'sd127;
            1:       c.departure_dbm = 8'sd0;
            default: c.departure_dbm = -8'($urandom_range(40, 120));
        endcase
        case ($urandom_range(0, 4))
            0:       c.entry_samples_needed = 4'd1;
            1:       c.entry_samples_needed = 4'd15;
            2:       c.entry_samples_needed = 4'($urandom_range(0, 15));
            default: c.entry_samples_needed = 4'($urandom_range(2, 6));
        endcase
        c.departure_timeout_ms = pick16(16'd1, 16'hFFFF, 300, 20000);
        c.freshness_ms         = pick16(16'd1, 16'hFFFF, 100, 5000);
        c.warning_delay_ms     = pick16(16'd0, 16'hFFFF, 0, 8000);
        return c;
    endfunction

    // one request through the sender; valid is left high for back-to-back use
    task automatic send_item(in_item_t it);
        int          gap;
        int unsigned pick;
        gap = 0;
        if ($urandom_range(0, 49) == 0) s_calm = !s_calm;
        if (!s_calm) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90)      gap = $urandom_range(8, 40);
            else if (pick >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_reqs++;
        expected_status.push_back(presence_update(it));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CONNECT_DBM:   regs.connect_dbm          = val[7:0];
            REG_DEPARTURE_DBM: regs.departure_dbm        = val[7:0];
            REG_ENTRY_SAMPLES: regs.entry_samples_needed = val[3:0];
            REG_TIMEOUT_MS:    regs.departure_timeout_ms = val;
            REG_FRESHNESS_MS:  regs.freshness_ms         = val;
            REG_WARNING_MS:    regs.warning_delay_ms     = val;
            default: ;
        endcase
    endtask

    // junk in the unused upper bits must be dropped by the narrow registers
    task automatic set_config(cfg_t c);
        write_reg(REG_CONNECT_DBM,   {8'($urandom), c.connect_dbm});
        write_reg(REG_DEPARTURE_DBM, {8'($urandom), c.departure_dbm});
        write_reg(REG_ENTRY_SAMPLES, {12'($urandom), c.entry_samples_needed});
        write_reg(REG_TIMEOUT_MS,    c.departure_timeout_ms);
        write_reg(REG_FRESHNESS_MS,  c.freshness_ms);
        write_reg(REG_WARNING_MS,    c.warning_delay_ms);
        write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 1)), 16'($urandom));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic test_reset_defaults();
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'd0));
        send_item(mk_item(CMD_SAMPLE, RSSI_INVALID, 40'd5));
        send_item(mk_item(CMD_SAMPLE, -8'sd128, 40'd10));
        send_item(mk_item(CMD_SAMPLE, 8'sd126, 40'd20));
        for (int i = 0; i < 4; i++)
            send_item(mk_item(CMD_SAMPLE, -8'sd20, 40'd100 + 40'(i * 100)));
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'd1000));
        send_item(mk_item(CMD_SAMPLE, -8'sd110, 40'd1500));
        send_item(mk_item(CMD_QUERY, RSSI_INVALID, 40'd3500));   // stale only
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'd5000));          // stale and late
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'd200));           // time behind stamps
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'hFF_FFFF_FFFF));
        send_item(mk_item(CMD_SAMPLE, -8'sd50, 40'hFF_FFFF_FFFF)); // expiry wipes
    endtask

    task automatic test_zero_limits();
        wait_idle();
        set_config('{8'sd0, -8'sd127, 4'd0, 16'd0, 16'd1, 16'd0});
        send_item(mk_item(CMD_SAMPLE, 8'sd0, 40'd100));   // near set, expires at once
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'd99));
        send_item(mk_item(CMD_SAMPLE, 8'sd10, 40'd100));
        send_item(mk_item(CMD_SAMPLE, 8'sd10, 40'd101));
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'hFF_FFFF_FFFF));
    endtask

    task automatic test_upper_limits();
        wait_idle();
        set_config('{-8'sd127, 8'sd0, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        for (int i = 0; i < 8; i++)
            send_item(mk_item(CMD_SAMPLE, -8'sd20, 40'h80_0000_0000 + 40'(i * 1000)));
        send_item(mk_item(CMD_QUERY, 8'sd0, 40'h80_0001_0000));
    endtask

    task automatic test_random_phases();
        cfg_t        c;
        logic [39:0] now_ms;
        int          mood;
        int          rssi;
        int          conn;
        int          dep;
        int          tmo;
        int          fresh;
        int unsigned pick;
        logic        cmd;
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            if (p == 0)
                c = '{RST_CONNECT_DBM, RST_DEPARTURE_DBM, RST_ENTRY_SAMPLES,
                      RST_TIMEOUT_MS, RST_FRESHNESS_MS, RST_WARNING_MS};
            else
                c = random_cfg();
            set_config(c);
            conn  = int'($signed(regs.connect_dbm));
            dep   = int'($signed(regs.departure_dbm));
            tmo   = int'(regs.departure_timeout_ms);
            fresh = int'(regs.freshness_ms);
            now_ms = p[0] ? {8'($urandom), 32'($urandom)} : 40'($urandom_range(0, 100000));
            mood   = 0;
            for (int k = 0; k < PHASE_REQS; k++) begin
                // moods: approaching (strong), lingering near departure, noise
                if ($urandom_range(0, 19) == 0) mood = $urandom_range(0, 2);
                pick = $urandom_range(0, 99);
                if (pick < 5)       ;
                else if (pick < 70) now_ms += $urandom_range(1, tmo / 3 + 1);
                else if (pick < 82) now_ms += $urandom_range(fresh / 2, fresh + fresh / 2 + 1);
                else if (pick < 92) now_ms += $urandom_range(tmo, 2 * tmo + 1);
                else if (pick < 97) now_ms -= $urandom_range(1, tmo + 1);
                else                now_ms = {8'($urandom), 32'($urandom)};
                pick = $urandom_range(0, 99);
                if (mood == 2 || pick >= 92) rssi = int'($urandom_range(0, 255)) - 128;
                else if (mood == 0)          rssi = conn - 2 + int'($urandom_range(0, 22));
                else                         rssi = dep - 8 + int'($urandom_range(0, 16));
                if (rssi > 126)  rssi = 126;
                if (rssi < -128) rssi = -128;
                if (pick >= 85 && pick < 92) rssi = int'(RSSI_INVALID);
                cmd = ($urandom_range(0, 99) < 15) ? CMD_QUERY : CMD_SAMPLE;
                send_item(mk_item(cmd, 8'(rssi), now_ms));
            end
        end
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        int unsigned pick;
        if ($urandom_range(0, 149) == 0) m_calm = !m_calm;
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else if (m_calm) begin
            m_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m_ready <= 1'b1;
            end else begin
                m_ready    <= 1'b0;
                stall_left = (pick < 92) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (expected_status.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("result %0d arrived with no request pending: %p",
                             n_checked, m_data);
            end else begin
                want = expected_status.pop_front();
                if (want.is_near) n_near++;
                if (want.departure_warning) n_warn++;
                if (m_data.is_near !== want.is_near ||
                    m_data.departure_grace !== want.departure_grace ||
                    m_data.departure_warning !== want.departure_warning ||
                    m_data.has_filtered !== want.has_filtered ||
                    m_data.filtered_dbm_q8 !== want.filtered_dbm_q8) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("result %0d near/grace/warn/has q8: exp %b%b%b%b %0d, got %b%b%b%b %0d",
                                 n_checked, want.is_near, want.departure_grace,
                                 want.departure_warning, want.has_filtered,
                                 want.filtered_dbm_q8, m_data.is_near,
                                 m_data.departure_grace, m_data.departure_warning,
                                 m_data.has_filtered, m_data.filtered_dbm_q8);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_status.size());
            $display("rssi_proximity_presence_filter_unit_tb failed");
            $finish;
        end
    end

    initial begin
        regs = '{RST_CONNECT_DBM, RST_DEPARTURE_DBM, RST_ENTRY_SAMPLES,
                 RST_TIMEOUT_MS, RST_FRESHNESS_MS, RST_WARNING_MS};
        clear_presence();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_zero_limits();
        test_upper_limits();
        test_random_phases();
        wait_idle();
        repeat (8) @(posedge aclk);
        $display("%0d requests over %0d register settings, %0d results checked",
                 n_reqs, n_settings, n_checked);
        $display("near reported %0d times, departure warning %0d times, %0d failures",
                 n_near, n_warn, n_fail);
        if (n_fail == 0 && expected_status.size() == 0)
            $display("rssi_proximity_presence_filter_unit_tb passed");
        else
            $display("rssi_proximity_presence_filter_unit_tb failed");
        $finish;
    end

endmodule
